>>> design/rqp_pkg.sv
// ----------------------------------------------------------------------------
// rqp_pkg - shared types and constants for the quantifier parser
// Holds the count limit, the byte codes, the parse phase codes and the
// structs that pass between the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rqp_pkg;

    // Count saturation: counts stop at COUNT_LIMIT-1, COUNT_LIMIT = unbounded
    localparam int COUNT_LIMIT = 65535;
    localparam int ACC_W       = $clog2(COUNT_LIMIT + 1);
    localparam int COUNT_W     = 16;

    typedef logic [ACC_W-1:0]   acc_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam acc_t ACC_UNBOUNDED = acc_t'(COUNT_LIMIT);
    localparam acc_t ACC_CAP       = acc_t'(COUNT_LIMIT - 1);

    // Pattern bytes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Parse phases
    localparam logic [2:0] PH_IDLE          = 3'd0;
    localparam logic [2:0] PH_LAZY          = 3'd1;
    localparam logic [2:0] PH_MIN           = 3'd2;
    localparam logic [2:0] PH_MAX_AFTER_MIN = 3'd3;
    localparam logic [2:0] PH_MAX_NO_MIN    = 3'd4;

    // Result status
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [2:0] phase;
        acc_t       min_acc;
        acc_t       max_acc;
        logic       digits_seen;
    } parse_st_t;

    typedef struct packed {
        logic [1:0] status;
        logic       lazy;
        count_t     min_count;
        count_t     max_count;
        logic       consumed;
    } parse_res_t;

    localparam parse_st_t ST_RESET = '{
        phase:       PH_IDLE,
        min_acc:     '0,
        max_acc:     ACC_UNBOUNDED,
        digits_seen: 1'b0
    };

    // Zero-extend or truncate an accumulator to the 16-bit result width
    function automatic count_t to_count(input acc_t acc);
        logic [ACC_W+COUNT_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, acc};
        return ext[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/regex_quantifier_parser.sv
// ----------------------------------------------------------------------------
// regex_quantifier_parser - streaming regex quantifier parser
// Reads pattern bytes one per item from a quantifier position and reports
// no quantifier, a parsed quantifier (lazy, min, max) or a syntax error.
// ----------------------------------------------------------------------------
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, char_byte                     | into block
//   out     | out_valid, out_ready, status, lazy, min_count,    | out of block
//           | max_count, byte_consumed                          |
//
// Cycles: one item per cycle sustained while the output is not stalled; a
//   result reaches the output through the input register and then the result
//   register: the byte that ends the quantifier sits in the input register, and
//   the combinational parse step fills the result register when it advances.
// Reset: rst_n clears the parse state to idle and empties both registers.
// Stalls: while a result waits in the output register and out_ready is low,
//   the held input item stays put and in_ready drops once it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module regex_quantifier_parser
    import rqp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   char_byte,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        status,
    output logic              lazy,
    output logic [COUNT_W-1:0] min_count,
    output logic [COUNT_W-1:0] max_count,
    output logic              byte_consumed
);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_reg;

    // Parse state
    parse_st_t  st_reg;
    parse_st_t  st_step;

    // Result register
    logic       out_valid_reg;
    logic       out_valid_next;
    parse_res_t res_reg;
    parse_res_t res_step;
    logic       emit;

    logic       advance;
    logic       in_take;

    // Advance the held item when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    rqp_step u_step (
        .st      (st_reg),
        .char_in (char_reg),
        .st_next (st_step),
        .emit    (emit),
        .res     (res_step)
    );

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        priority if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= ST_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_step;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_byte;
        end
        if (advance && emit)
        begin
            res_reg <= res_step;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign lazy          = res_reg.lazy;
    assign min_count     = res_reg.min_count;
    assign max_count     = res_reg.max_count;
    assign byte_consumed = res_reg.consumed;

    // A shown result never carries the unused status code
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.status == ST_NONE || res_reg.status == ST_OK
                           || res_reg.status == ST_ERR))
        else $error("result status out of range");

    // Only a parsed quantifier carries counts or a lazy flag
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status != ST_OK) |->
            (!res_reg.lazy && res_reg.min_count == '0
             && res_reg.max_count == '0 && !res_reg.consumed))
        else $error("non-quantifier result carries data");

    // A byte is consumed at the end only as the lazy question mark
    a_consumed_lazy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.consumed) |-> (res_reg.lazy && res_reg.status == ST_OK))
        else $error("consumed byte without lazy flag");

    // Idle phase always holds the cleared accumulators
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_IDLE) |->
            (st_reg.min_acc == '0 && st_reg.max_acc == ACC_UNBOUNDED
             && !st_reg.digits_seen))
        else $error("idle phase with stale accumulators");

    // An emitted result enters the output register on the next edge
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid_reg)
        else $error("emitted result lost");

endmodule

`default_nettype wire

>>> design/rqp_sat_acc.sv
// ----------------------------------------------------------------------------
// rqp_sat_acc - saturating decimal accumulator
// Computes acc*10 + digit, clamped to the count cap.
// ----------------------------------------------------------------------------
`default_nettype none

module rqp_sat_acc
    import rqp_pkg::*;
(
    input  wire acc_t       acc_in,
    input  wire logic [3:0] digit,
    output acc_t            acc_out
);

    localparam int PW = ACC_W + 4;

    logic [PW-1:0] base;
    logic [PW-1:0] prod;

    always_comb
    begin
        base = (acc_in > ACC_CAP) ? PW'(ACC_CAP) : PW'(acc_in);
        // times ten as two shifts and an add
        prod = (base << 3) + (base << 1) + PW'(digit);
        acc_out = (prod > PW'(ACC_CAP)) ? ACC_CAP : prod[ACC_W-1:0];
    end

endmodule

`default_nettype wire

>>> design/rqp_step.sv
// ----------------------------------------------------------------------------
// rqp_step - one-byte parse step
// Next parse state and optional result for one pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rqp_step
    import rqp_pkg::*;
(
    input  wire parse_st_t  st,
    input  wire logic [7:0] char_in,
    output parse_st_t       st_next,
    output logic            emit,
    output parse_res_t      res
);

    logic is_digit;
    acc_t acc_src;
    acc_t acc_new;

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    // Only one count grows per byte: min in the min phase, max otherwise
    assign acc_src  = (st.phase == PH_MIN) ? st.min_acc : st.max_acc;

    rqp_sat_acc u_acc (
        .acc_in  (acc_src),
        .digit   (char_in[3:0]),
        .acc_out (acc_new)
    );

    always_comb
    begin
        st_next = st;
        emit    = 1'b0;
        res     = '0;
        unique case (st.phase)
            PH_LAZY:
            begin
                emit          = 1'b1;
                res.status    = ST_OK;
                res.lazy      = (char_in == CH_QMARK);
                res.consumed  = (char_in == CH_QMARK);
                res.min_count = to_count(st.min_acc);
                res.max_count = to_count(st.max_acc);
                st_next       = ST_RESET;
            end
            PH_MIN:
            begin
                priority if (is_digit)
                begin
                    st_next.min_acc     = acc_new;
                    st_next.digits_seen = 1'b1;
                end
                else if (char_in == CH_RBRACE)
                begin
                    if (st.digits_seen)
                    begin
                        st_next.max_acc = st.min_acc;
                    end
                    else
                    begin
                        st_next.min_acc = '0;
                        st_next.max_acc = ACC_UNBOUNDED;
                    end
                    st_next.phase = PH_LAZY;
                end
                else if (char_in == CH_COMMA)
                begin
                    st_next.phase = st.digits_seen ? PH_MAX_AFTER_MIN : PH_MAX_NO_MIN;
                    if (!st.digits_seen)
                    begin
                        st_next.min_acc = '0;
                    end
                    st_next.max_acc     = '0;
                    st_next.digits_seen = 1'b0;
                end
                else
                begin
                    emit       = 1'b1;
                    res.status = ST_ERR;
                    st_next    = ST_RESET;
                end
            end
            PH_MAX_AFTER_MIN, PH_MAX_NO_MIN:
            begin
                priority if (is_digit)
                begin
                    st_next.max_acc     = acc_new;
                    st_next.digits_seen = 1'b1;
                end
                else if (char_in == CH_RBRACE && !st.digits_seen
                         && st.phase == PH_MAX_NO_MIN)
                begin
                    // "{,}" has no bound at all
                    emit       = 1'b1;
                    res.status = ST_ERR;
                    st_next    = ST_RESET;
                end
                else if (char_in == CH_RBRACE)
                begin
                    if (!st.digits_seen)
                    begin
                        st_next.max_acc = ACC_UNBOUNDED;
                    end
                    st_next.phase = PH_LAZY;
                end
                else
                begin
                    emit       = 1'b1;
                    res.status = ST_ERR;
                    st_next    = ST_RESET;
                end
            end
            default:
            begin
                // idle and unused codes
                st_next = ST_RESET;
                priority if (char_in == CH_STAR)
                begin
                    st_next.phase = PH_LAZY;
                end
                else if (char_in == CH_PLUS)
                begin
                    st_next.min_acc = acc_t'(1);
                    st_next.phase   = PH_LAZY;
                end
                else if (char_in == CH_QMARK)
                begin
                    st_next.max_acc = acc_t'(1);
                    st_next.phase   = PH_LAZY;
                end
                else if (char_in == CH_LBRACE)
                begin
                    st_next.phase = PH_MIN;
                end
                else
                begin
                    emit       = 1'b1;
                    res.status = ST_NONE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
